// ===== hdl/gfexp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfexp_pkg
// Shared widths, register indexes and controller states for the GF(2^m)
// exponentiation block.
// ----------------------------------------------------------------------------
package gfexp_pkg;

	// Field widths of the channels
	localparam int BASE_W = 32;
	localparam int EXP_W  = 64;
	localparam int RES_W  = 32;

	// Exponent bit counter
	localparam int EXP_CNT_W = $clog2(EXP_W);

	// Configuration registers
	localparam int DEG_W    = 6;
	localparam int POLY_W   = 32;
	localparam int APB_W    = 32;
	localparam int ADDR_W   = 3;
	localparam int REG_IDX_W = 1;

	localparam logic [DEG_W-1:0]  DEG_RESET  = 6'd8;
	localparam logic [POLY_W-1:0] POLY_RESET = 32'd29;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_FIELD_DEGREE   = 1'b0,
		REG_REDUCTION_POLY = 1'b1
	} gfexp_reg_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_MSTART,
		ST_MWAIT,
		ST_FINISH
	} gfexp_state_t;

endpackage

// ===== hdl/gfexp_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfexp_in_if
// Operand channel: base element and exponent with valid/ready handshake.
// ----------------------------------------------------------------------------
interface gfexp_in_if import gfexp_pkg::*; ();

	logic              valid;
	logic              ready;
	logic [BASE_W-1:0] base;
	logic [EXP_W-1:0]  exponent;

	modport source (output valid, output base, output exponent, input ready);
	modport sink   (input valid, input base, input exponent, output ready);

endinterface

// ===== hdl/gfexp_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfexp_out_if
// Result channel: power result with valid/ready handshake.
// ----------------------------------------------------------------------------
interface gfexp_out_if import gfexp_pkg::*; ();

	logic             valid;
	logic             ready;
	logic [RES_W-1:0] power_result;

	modport source (output valid, output power_result, input ready);
	modport sink   (input valid, input power_result, output ready);

endinterface

// ===== hdl/gf2m_exponentiation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf2m_exponentiation
// Raises a GF(2^m) element to an unsigned 64-bit power, polynomial basis.
// ----------------------------------------------------------------------------
// One transaction at a time. The exponent is first reduced modulo 2^m - 1 by a
// bit-serial unit. If the remainder is zero the result is 1. Otherwise each
// remaining exponent bit, LSB first, takes one round of the two bit-serial
// multipliers (r*p and p*p run side by side); the number of rounds is the bit
// length of the reduced exponent (at most m). The result waits in an output
// register, so the next operand is taken once the controller is back in
// idle. Registers sit on an APB port: field_degree at 0x0 (reset 8, 0 acts
// as 1, values above the FIELD_DEG_MAX parameter clamp to it), reduction_poly
// at 0x4 (reset 0x1D, x^m implicit).
// ----------------------------------------------------------------------------
module gf2m_exponentiation import gfexp_pkg::*; #(
	parameter int FIELD_DEG_MAX = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [APB_W-1:0]  pwdata,
	output logic [APB_W-1:0]  prdata,
	output logic              pready,
	gfexp_in_if.sink          operand,
	gfexp_out_if.source       result
);

	localparam int W  = FIELD_DEG_MAX;
	localparam int IW = $clog2(W);
	localparam logic [DEG_W-1:0] DEG_LIM = DEG_W'(FIELD_DEG_MAX);

	// register file
	logic [DEG_W-1:0]  deg_q;
	logic [POLY_W-1:0] poly_q;
	gfexp_reg_t        reg_idx;
	logic              cfg_wr;

	// field setup
	logic [DEG_W-1:0] m_eff;
	logic [IW-1:0]    m_idx;
	logic [W-1:0]     mask;
	logic [63:0]      poly_ext;
	logic [63:0]      base_ext;
	logic [W-1:0]     poly_m;
	logic [W-1:0]     base_m;

	// controller and datapath
	gfexp_state_t state_q, state_d;
	logic         red_start;
	logic         red_done;
	logic [W-1:0] red_rem;
	logic         mul_start;
	logic         mul_done_r;
	logic         mul_done_p;
	logic [W-1:0] prod_r;
	logic [W-1:0] prod_p;
	logic [W-1:0] n_q;
	logic [W-1:0] p_q;
	logic [W-1:0] r_q;
	logic [63:0]  res_ext;
	logic         out_valid_q;
	logic         accept;
	logic         out_free;

	// APB access
	assign pready  = 1'b1;
	assign reg_idx = gfexp_reg_t'(paddr[ADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_q  <= DEG_RESET;
			poly_q <= POLY_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_FIELD_DEGREE:   deg_q  <= pwdata[DEG_W-1:0];
				REG_REDUCTION_POLY: poly_q <= pwdata[POLY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_FIELD_DEGREE:   prdata = APB_W'(deg_q);
			REG_REDUCTION_POLY: prdata = APB_W'(poly_q);
			default:            prdata = '0;
		endcase
	end

	// effective degree, mask and masked operands
	always_comb begin
		if (deg_q == '0)
			m_eff = DEG_W'(1);
		else if (deg_q > DEG_LIM)
			m_eff = DEG_LIM;
		else
			m_eff = deg_q;
		m_idx = IW'(m_eff - DEG_W'(1));
		for (int i = 0; i < W; i++)
			mask[i] = (IW'(i) <= m_idx);
		poly_ext = 64'(poly_q);
		base_ext = 64'(operand.base);
		poly_m   = poly_ext[W-1:0] & mask;
		base_m   = base_ext[W-1:0] & mask;
	end

	// exponent reduction
	gfexp_modred #(.W(W), .IW(IW)) u_modred (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (red_start),
		.exponent  (operand.exponent),
		.m_idx     (m_idx),
		.mask      (mask),
		.done      (red_done),
		.remainder (red_rem)
	);

	// r * p
	gfexp_mul #(.W(W), .IW(IW)) u_mul_r (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (r_q),
		.b      (p_q),
		.poly   (poly_m),
		.mask   (mask),
		.m_idx  (m_idx),
		.done   (mul_done_r),
		.prod   (prod_r)
	);

	// p * p
	gfexp_mul #(.W(W), .IW(IW)) u_mul_p (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (p_q),
		.b      (p_q),
		.poly   (poly_m),
		.mask   (mask),
		.m_idx  (m_idx),
		.done   (mul_done_p),
		.prod   (prod_p)
	);

	assign operand.ready = (state_q == ST_IDLE);
	assign accept        = operand.valid && operand.ready;
	assign out_free      = !out_valid_q || result.ready;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// next state and unit starts
	always_comb begin
		state_d   = state_q;
		red_start = 1'b0;
		mul_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					red_start = 1'b1;
					state_d   = ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				if (red_done)
					state_d = (red_rem == '0) ? ST_FINISH : ST_MSTART;
			end
			ST_MSTART: begin
				mul_start = 1'b1;
				state_d   = ST_MWAIT;
			end
			ST_MWAIT: begin
				if (mul_done_r && mul_done_p)
					state_d = ((n_q >> 1) == '0) ? ST_FINISH : ST_MSTART;
			end
			ST_FINISH: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// exponent, power and accumulator registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					p_q <= base_m;
					r_q <= W'(1);
				end
			end
			ST_REDUCE: begin
				if (red_done)
					n_q <= red_rem;
			end
			ST_MWAIT: begin
				if (mul_done_r && mul_done_p) begin
					if (n_q[0])
						r_q <= prod_r;
					p_q <= prod_p;
					n_q <= n_q >> 1;
				end
			end
			default: ;
		endcase
	end

	// output register
	assign res_ext = 64'(r_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FINISH && out_free)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free)
			result.power_result <= res_ext[RES_W-1:0];
	end

	assign result.valid = out_valid_q;

endmodule

// ===== hdl/gfexp_modred.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfexp_modred
// Bit-serial reduction of the exponent modulo 2^m - 1. The exponent is
// shifted in MSB first; doubling modulo 2^m - 1 is a rotate within m bits.
// ----------------------------------------------------------------------------
module gfexp_modred import gfexp_pkg::*; #(
	parameter int W  = 32,
	parameter int IW = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [EXP_W-1:0] exponent,
	input  logic [IW-1:0]    m_idx,
	input  logic [W-1:0]     mask,
	output logic             done,
	output logic [W-1:0]     remainder
);

	logic                 busy_q;
	logic                 done_q;
	logic [EXP_CNT_W-1:0] cnt_q;
	logic [EXP_W-1:0]     e_q;
	logic [W-1:0]         r_q;
	logic [W-1:0]         rot;
	logic [W-1:0]         sum;
	logic [W-1:0]         r_next;

	// rotate left within m bits, then add the incoming bit
	always_comb begin
		rot    = ((r_q << 1) | W'(r_q[m_idx])) & mask;
		sum    = rot + W'(e_q[EXP_W-1]);
		r_next = (sum == mask) ? '0 : sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= EXP_CNT_W'(EXP_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - EXP_CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			e_q <= exponent;
			r_q <= '0;
		end else if (busy_q) begin
			e_q <= e_q << 1;
			r_q <= r_next;
		end
	end

	assign done      = done_q;
	assign remainder = r_q;

endmodule

// ===== hdl/gfexp_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfexp_mul
// Bit-serial GF(2^m) multiplier, MSB first, one bit of b per cycle with
// interleaved reduction by the modulus polynomial.
// ----------------------------------------------------------------------------
module gfexp_mul import gfexp_pkg::*; #(
	parameter int W  = 32,
	parameter int IW = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [W-1:0]  a,
	input  logic [W-1:0]  b,
	input  logic [W-1:0]  poly,
	input  logic [W-1:0]  mask,
	input  logic [IW-1:0] m_idx,
	output logic          done,
	output logic [W-1:0]  prod
);

	logic          busy_q;
	logic          done_q;
	logic [IW-1:0] cnt_q;
	logic [W-1:0]  a_q;
	logic [W-1:0]  b_q;
	logic [W-1:0]  r_q;
	logic [W-1:0]  r_next;

	// shift-and-add step with reduction of the bit leaving position m-1
	always_comb begin
		r_next = (r_q << 1) & mask;
		if (r_q[m_idx]) r_next = r_next ^ poly;
		if (b_q[m_idx]) r_next = r_next ^ a_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= m_idx;
			end else if (busy_q) begin
				cnt_q <= cnt_q - IW'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			r_q <= '0;
		end else if (busy_q) begin
			b_q <= b_q << 1;
			r_q <= r_next;
		end
	end

	assign done = done_q;
	assign prod = r_q;

endmodule
